@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the lattice checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// hold b in the same cycle as a, outside reset
`define AST_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// hold b in the cycle after a, outside reset
`define AST_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

// hold b in the cycle after a, reset included
`define AST_NEXT_NR(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed");

`endif

@@ rtl/lgl_pkg.sv @@
// ---------------------------------------------------------------------------
// lgl_pkg
// Shared codes, types and the gate function of the gate neuron lattice.
// ---------------------------------------------------------------------------
package lgl_pkg;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_SPIKE = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic [2:0] GATE_XOR  = 3'd0;
  localparam logic [2:0] GATE_NAND = 3'd1;
  localparam logic [2:0] GATE_OR   = 3'd2;
  localparam logic [2:0] GATE_AND  = 3'd3;
  localparam logic [2:0] GATE_NOR  = 3'd4;

  localparam int DELAY_W = 5;

  typedef struct packed {
    logic                 armed;
    logic [DELAY_W-1:0]   timer;
  } lgl_syn_t;

  function automatic logic gate_eval(input logic [2:0] g, input logic a, input logic b);
    logic r;
    case (g)
      GATE_XOR:  r = a ^ b;
      GATE_NAND: r = ~(a & b);
      GATE_OR:   r = a | b;
      GATE_AND:  r = a & b;
      GATE_NOR:  r = ~(a | b);
      default:   r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/lgl_ram.sv @@
// ---------------------------------------------------------------------------
// lgl_ram
// Single write port, single read port synchronous RAM, registered read.
// ---------------------------------------------------------------------------
module lgl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lgl_syn_update.sv @@
// ---------------------------------------------------------------------------
// lgl_syn_update
// Synapse lanes of one neuron: arm, time out, fire and fold the flux parity.
// ---------------------------------------------------------------------------
module lgl_syn_update #(
  parameter int SYNAPSES = 12
) (
  input  logic                                  gate_hit,
  input  logic [SYNAPSES*lgl_pkg::DELAY_W-1:0]  delays,
  input  lgl_pkg::lgl_syn_t [SYNAPSES-1:0]      syn_in,
  output lgl_pkg::lgl_syn_t [SYNAPSES-1:0]      syn_out,
  output logic                                  flux
);

  logic [SYNAPSES-1:0] fire;

  always_comb begin
    fire    = '0;
    syn_out = syn_in;
    for (int j = 0; j < SYNAPSES; j++) begin
      if (syn_in[j].armed || gate_hit) begin
        if (syn_in[j].timer >= delays[j*lgl_pkg::DELAY_W +: lgl_pkg::DELAY_W]) begin
          fire[j]    = 1'b1;
          syn_out[j] = '0;
        end else begin
          syn_out[j].armed = 1'b1;
          syn_out[j].timer = syn_in[j].timer + 1'b1;
        end
      end
    end
  end

  assign flux = ^fire;

endmodule

@@ rtl/logic_gate_lattice_tick.sv @@
// ---------------------------------------------------------------------------
// logic_gate_lattice_tick
// Gate neuron lattice: descriptor load, spike word write and in-place tick.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one item per beat: kind 0 loads a
// neuron descriptor, kind 1 writes a 64-bit spike word, kind 2 runs a tick.
// A spike word is written in the cycle it is accepted. A load runs the modulo
// reduction of the source and link fields in ST_LD1 and ST_LD2, and writes the
// descriptor in ST_LD2. A tick walks the neurons in ascending order, each through
// ST_TA (descriptor/synapse read), ST_TB (neighbour/spike read) and ST_TC (update
// and write back through the one state RAM port).
// Output channel (out_valid/out_ready) carries NEURONS/64 beats per tick,
// word index ascending, last set on the final one. A beat sits in an output
// register; when it is still held at the end of the next 64-neuron group
// the walk stalls until it is taken.
// After reset a clearing pass zeroes the state, synapse and spike RAMs;
// in_ready stays low during it.
// ---------------------------------------------------------------------------
module logic_gate_lattice_tick #(
  parameter int NEURONS    = 1024,
  parameter int SYNAPSES   = 12,
  parameter int SPIKE_BITS = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [9:0]  neuron_index,
  input  logic [2:0]  gate_type,
  input  logic [13:0] external_source,
  input  logic [9:0]  neighbour_source,
  input  logic        initial_state,
  input  logic [59:0] delays_packed,
  input  logic [7:0]  spike_word_index,
  input  logic [63:0] spike_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  output_word_index,
  output logic [63:0] output_word,
  output logic        last
);

  localparam int NW      = $clog2(NEURONS);
  localparam int SBW     = $clog2(SPIKE_BITS);
  localparam int SW      = (SPIKE_BITS + 63) / 64;
  localparam int SWW     = (SW > 1) ? $clog2(SW) : 1;
  localparam int DLW     = SYNAPSES * lgl_pkg::DELAY_W;
  localparam int SYW     = SYNAPSES * $bits(lgl_pkg::lgl_syn_t);
  localparam int DW      = 3 + SBW + NW + DLW;
  localparam int CLR_LEN = (NEURONS > SW) ? NEURONS : SW;
  localparam int CW      = $clog2(CLR_LEN);
  localparam logic [32:0] SRC_RECIP  = 33'((64'd1 << 32) / SPIKE_BITS);
  localparam logic [32:0] LINK_RECIP = 33'((64'd1 << 32) / NEURONS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LD1   = 3'd2;
  localparam logic [2:0] ST_LD2   = 3'd3;
  localparam logic [2:0] ST_TA    = 3'd4;
  localparam logic [2:0] ST_TB    = 3'd5;
  localparam logic [2:0] ST_TC    = 3'd6;

  logic [2:0]      state;
  logic [CW-1:0]   clr;
  logic [NW-1:0]   idx;
  logic [63:0]     acc;

  logic [NW-1:0]   ld_addr;
  logic [2:0]      ld_gate;
  logic [13:0]     ld_src;
  logic [9:0]      ld_link;
  logic            ld_init;
  logic [DLW-1:0]  ld_delays;
  logic [13:0]     q_src;
  logic [9:0]      q_link;

  logic            own_st;
  logic [5:0]      bitsel;

  logic            st_we, st_wd, st_rd;
  logic [NW-1:0]   st_waddr, st_raddr;
  logic            sy_we;
  logic [SYW-1:0]  sy_wd, sy_rd;
  logic [NW-1:0]   sy_waddr;
  logic            dc_we;
  logic [DW-1:0]   dc_wd, dc_rd;
  logic            sp_we;
  logic [SWW-1:0]  sp_waddr, sp_raddr;
  logic [63:0]     sp_wd, sp_rd;

  logic [2:0]      d_gate;
  logic [SBW-1:0]  d_src;
  logic [NW-1:0]   d_link;
  logic [DLW-1:0]  d_delays;

  logic            accept, g, flux, new_st, word_done, push, advance;
  lgl_pkg::lgl_syn_t [SYNAPSES-1:0] syn_cur;
  lgl_pkg::lgl_syn_t [SYNAPSES-1:0] syn_new;
  logic [31:0]     r_src, r_link;
  logic [SBW-1:0]  src_red;
  logic [NW-1:0]   link_red;

  assign {d_gate, d_src, d_link, d_delays} = dc_rd;
  assign syn_cur = sy_rd;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign g         = lgl_pkg::gate_eval(d_gate, sp_rd[bitsel], st_rd);
  assign new_st    = own_st ^ flux;
  assign word_done = (idx[5:0] == 6'd63) || (idx == NW'(NEURONS - 1));
  assign push      = (state == ST_TC) && word_done && (!out_valid || out_ready);
  assign advance   = (state == ST_TC) && (!word_done || !out_valid || out_ready);

  always_comb begin
    r_src  = 32'(ld_src) - 32'(32'(q_src) * SPIKE_BITS);
    if (r_src >= 32'(SPIKE_BITS)) begin
      r_src = r_src - 32'(SPIKE_BITS);
    end
    r_link = 32'(ld_link) - 32'(32'(q_link) * NEURONS);
    if (r_link >= 32'(NEURONS)) begin
      r_link = r_link - 32'(NEURONS);
    end
    src_red  = SBW'(r_src);
    link_red = NW'(r_link);
  end

  lgl_syn_update #(.SYNAPSES(SYNAPSES)) u_syn (
    .gate_hit (g),
    .delays   (d_delays),
    .syn_in   (syn_cur),
    .syn_out  (syn_new),
    .flux     (flux)
  );

  always_comb begin
    st_we = 1'b0; st_waddr = idx; st_wd = new_st;
    sy_we = 1'b0; sy_waddr = idx; sy_wd = SYW'(syn_new);
    dc_we = (state == ST_LD2);
    dc_wd = {ld_gate, src_red, link_red, ld_delays};
    sp_we = 1'b0; sp_waddr = SWW'(spike_word_index); sp_wd = spike_word;
    st_raddr = idx;
    sp_raddr = SWW'(d_src >> 6);
    case (state)
      ST_CLEAR: begin
        st_we    = (32'(clr) < NEURONS);
        sy_we    = st_we;
        st_waddr = NW'(clr);
        sy_waddr = NW'(clr);
        st_wd    = 1'b0;
        sy_wd    = '0;
        sp_we    = (32'(clr) < SW);
        sp_waddr = SWW'(clr);
        sp_wd    = '0;
      end
      ST_IDLE: begin
        sp_we = accept && (kind == lgl_pkg::KIND_SPIKE) && (32'(spike_word_index) < SW);
      end
      ST_LD2: begin
        st_we    = 1'b1;
        sy_we    = 1'b1;
        st_waddr = ld_addr;
        sy_waddr = ld_addr;
        st_wd    = ld_init;
        sy_wd    = '0;
      end
      ST_TB, ST_TC: begin
        st_raddr = d_link;
        st_we    = advance;
        sy_we    = advance;
      end
      default: begin
      end
    endcase
  end

  lgl_ram #(.WIDTH(1), .DEPTH(NEURONS)) u_state (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wd), .raddr(st_raddr), .rdata(st_rd)
  );

  lgl_ram #(.WIDTH(SYW), .DEPTH(NEURONS)) u_synapse (
    .clk, .we(sy_we), .waddr(sy_waddr), .wdata(sy_wd), .raddr(idx), .rdata(sy_rd)
  );

  lgl_ram #(.WIDTH(DW), .DEPTH(NEURONS)) u_desc (
    .clk, .we(dc_we), .waddr(ld_addr), .wdata(dc_wd), .raddr(idx), .rdata(dc_rd)
  );

  lgl_ram #(.WIDTH(64), .DEPTH(SW), .AW(SWW)) u_spike (
    .clk, .we(sp_we), .waddr(sp_waddr), .wdata(sp_wd), .raddr(sp_raddr), .rdata(sp_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      idx       <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= push || (out_valid && !out_ready);
      case (state)
        ST_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == CW'(CLR_LEN - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (kind == lgl_pkg::KIND_LOAD && 32'(neuron_index) < NEURONS) begin
              state <= ST_LD1;
            end else if (kind == lgl_pkg::KIND_TICK) begin
              idx   <= '0;
              acc   <= '0;
              state <= ST_TA;
            end
          end
        end
        ST_LD1: state <= ST_LD2;
        ST_LD2: state <= ST_IDLE;
        ST_TA:  state <= ST_TB;
        ST_TB:  state <= ST_TC;
        ST_TC: begin
          if (advance) begin
            acc <= word_done ? '0 : (acc | (64'(new_st) << idx[5:0]));
            if (idx == NW'(NEURONS - 1)) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_TA;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ld_addr   <= NW'(neuron_index);
      ld_gate   <= gate_type;
      ld_src    <= external_source;
      ld_link   <= neighbour_source;
      ld_init   <= initial_state;
      ld_delays <= DLW'(delays_packed);
    end
    if (state == ST_LD1) begin
      q_src  <= 14'((48'(ld_src) * 48'(SRC_RECIP)) >> 32);
      q_link <= 10'((48'(ld_link) * 48'(LINK_RECIP)) >> 32);
    end
    if (state == ST_TB) begin
      own_st <= st_rd;
      bitsel <= d_src[5:0];
    end
    if (push) begin
      output_word_index <= 4'(idx >> 6);
      output_word       <= acc | (64'(new_st) << idx[5:0]);
      last              <= (idx == NW'(NEURONS - 1));
    end
  end

endmodule

@@ rtl/lgl_checker.sv @@
// ---------------------------------------------------------------------------
// lgl_checker
// Port-level checks of the gate neuron lattice, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lgl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] output_word,
  input logic        last
);

  `AST_NEXT_NR(a_reset_quiet, clk, rst, !in_ready && !out_valid)
  `AST_NEXT(a_tick_busy, clk, rst, in_valid && in_ready && kind == lgl_pkg::KIND_TICK, !in_ready)
  `AST_IMPLY(a_idle_only_last, clk, rst, in_ready && out_valid, last)
  `AST_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(output_word))

endmodule

bind logic_gate_lattice_tick lgl_checker u_lgl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .kind        (kind),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .output_word (output_word),
  .last        (last)
);
